// ===== hw/rtl/gcdf_pkg.sv =====
// Package for the gateway command deframer: payload structs, parser codes,
// controller/datapath command and status types, and the identifier reply.
// No dependencies; every other file in hw/rtl uses it.
package gcdf_pkg;

    // Width of a frame length field as carried on the stream (two bytes).
    localparam int LEN_W = 16;
    // Number of significant bits a frame length may have (8 to 16).
    localparam int LENGTH_BITS = 16;
    // Largest length the length counter can hold.
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'((32'd1 << LENGTH_BITS) - 32'd1);
    // Reset value of the max_frame_len register.
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(8000);

    // Command bytes.
    localparam logic [7:0] CMD_IDENT = 8'h48;
    localparam logic [7:0] CMD_KEEP  = 8'h4B;
    localparam logic [7:0] CMD_SEND  = 8'h53;

    // Identifier reply sent for an identify command.
    localparam int REPLY_LEN = 10;
    localparam int REPLY_IDX_W = $clog2(REPLY_LEN);

    // Character of the identifier reply at a given position.
    function automatic logic [7:0] reply_char(input logic [REPLY_IDX_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            REPLY_IDX_W'(0): ch = 8'h48;
            REPLY_IDX_W'(1): ch = 8'h48;
            REPLY_IDX_W'(2): ch = 8'h4D;
            REPLY_IDX_W'(3): ch = 8'h2D;
            REPLY_IDX_W'(4): ch = 8'h55;
            REPLY_IDX_W'(5): ch = 8'h53;
            REPLY_IDX_W'(6): ch = 8'h42;
            REPLY_IDX_W'(7): ch = 8'h2D;
            REPLY_IDX_W'(8): ch = 8'h49;
            REPLY_IDX_W'(9): ch = 8'h46;
            default:         ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Result routes.
    typedef enum logic [1:0] {
        ROUTE_REPLY   = 2'd0,
        ROUTE_PAYLOAD = 2'd1,
        ROUTE_ABORT   = 2'd2
    } t_route;

    // Parser phases.
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_LEN_HIGH = 2'd1,
        PH_LEN_LOW  = 2'd2,
        PH_PAYLOAD  = 2'd3
    } t_phase;

    // Input request kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // One input request.
    typedef struct packed {
        logic       kind;
        logic [7:0] in_byte;
    } t_in_item;

    // One result.
    typedef struct packed {
        t_route     out_route;
        logic [7:0] out_byte;
        logic       out_last;
        logic       out_empty;
    } t_out_item;

    // What the datapath makes of the byte it is currently looking at.
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_EMIT,
        ACT_REPLY,
        ACT_RESYNC
    } t_action;

    // Source of the byte fed to the parser.
    typedef enum logic [1:0] {
        SRC_IN,
        SRC_HI,
        SRC_LO
    } t_src;

    // Controller states.
    typedef enum logic [2:0] {
        ST_RUN,
        ST_HI,
        ST_LO,
        ST_REPLY_RUN,
        ST_REPLY_LO
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic exec;
        t_src src;
        logic reply_step;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic    slot_free;
        t_action action;
        logic    reply_last;
    } t_status;

endpackage

// ===== hw/rtl/gcdf_datapath.sv =====
// Datapath of the gateway command deframer: parser state, length limit
// register, replay bytes, reply counter and the output register.
// Depends on gcdf_pkg.
module gcdf_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  gcdf_pkg::t_in_item      i_in_data,
    input  logic                    i_cfg_we,
    input  logic [gcdf_pkg::LEN_W-1:0] i_cfg_wdata,
    input  logic                    i_out_stall,
    input  gcdf_pkg::t_cmd          i_cmd,
    output gcdf_pkg::t_status       o_status,
    output logic                    o_out_valid,
    output gcdf_pkg::t_out_item     o_out_data
);

    gcdf_pkg::t_phase                      r_phase, n_phase;
    logic [7:0]                            r_len_high, n_len_high;
    logic [gcdf_pkg::LENGTH_BITS-1:0]      r_bytes_left, n_bytes_left;
    logic [gcdf_pkg::LEN_W-1:0]            r_max_len;
    logic [7:0]                            r_replay_hi, n_replay_hi;
    logic [7:0]                            r_replay_lo, n_replay_lo;
    logic [gcdf_pkg::REPLY_IDX_W-1:0]      r_reply_idx, n_reply_idx;
    logic                                  r_out_valid, n_out_valid;
    gcdf_pkg::t_out_item                   r_out, n_out;

    logic [7:0]                 cur_byte;
    logic                       is_end;
    logic [gcdf_pkg::LEN_W-1:0] frame_len;
    logic [gcdf_pkg::LEN_W-1:0] limit;
    gcdf_pkg::t_action          action;
    gcdf_pkg::t_out_item        exec_item;
    gcdf_pkg::t_out_item        reply_item;
    logic                       slot_free;
    logic                       load;

    // Byte under inspection and the effective length limit.
    always_comb begin
        case (i_cmd.src)
            gcdf_pkg::SRC_HI: cur_byte = r_replay_hi;
            gcdf_pkg::SRC_LO: cur_byte = r_replay_lo;
            default:          cur_byte = i_in_data.in_byte;
        endcase
        is_end    = (i_cmd.src == gcdf_pkg::SRC_IN) && (i_in_data.kind == gcdf_pkg::KIND_END);
        frame_len = {r_len_high, cur_byte};
        limit     = (r_max_len < gcdf_pkg::LEN_CAP) ? r_max_len : gcdf_pkg::LEN_CAP;
    end

    // Parser step for one byte or session end.
    always_comb begin
        n_phase      = r_phase;
        n_len_high   = r_len_high;
        n_bytes_left = r_bytes_left;
        n_replay_hi  = r_replay_hi;
        n_replay_lo  = r_replay_lo;
        n_reply_idx  = r_reply_idx;
        action       = gcdf_pkg::ACT_NONE;
        exec_item    = '0;
        if (is_end) begin
            if (r_phase == gcdf_pkg::PH_PAYLOAD) begin
                action              = gcdf_pkg::ACT_EMIT;
                exec_item.out_route = gcdf_pkg::ROUTE_ABORT;
            end
            n_phase      = gcdf_pkg::PH_IDLE;
            n_len_high   = '0;
            n_bytes_left = '0;
        end else begin
            case (r_phase)
                gcdf_pkg::PH_PAYLOAD: begin
                    action              = gcdf_pkg::ACT_EMIT;
                    exec_item.out_route = gcdf_pkg::ROUTE_PAYLOAD;
                    exec_item.out_byte  = cur_byte;
                    if (r_bytes_left <= gcdf_pkg::LENGTH_BITS'(1)) begin
                        exec_item.out_last = 1'b1;
                        n_bytes_left       = '0;
                        n_phase            = gcdf_pkg::PH_IDLE;
                    end else begin
                        n_bytes_left = r_bytes_left - gcdf_pkg::LENGTH_BITS'(1);
                    end
                end
                gcdf_pkg::PH_LEN_LOW: begin
                    n_len_high = '0;
                    if (frame_len > limit) begin
                        // Oversized length: drop the send command, replay both length bytes.
                        action      = gcdf_pkg::ACT_RESYNC;
                        n_replay_hi = r_len_high;
                        n_replay_lo = cur_byte;
                        n_phase     = gcdf_pkg::PH_IDLE;
                    end else if (frame_len == '0) begin
                        action              = gcdf_pkg::ACT_EMIT;
                        exec_item.out_route = gcdf_pkg::ROUTE_PAYLOAD;
                        exec_item.out_last  = 1'b1;
                        exec_item.out_empty = 1'b1;
                        n_phase             = gcdf_pkg::PH_IDLE;
                        n_bytes_left        = '0;
                    end else begin
                        n_bytes_left = frame_len[gcdf_pkg::LENGTH_BITS-1:0];
                        n_phase      = gcdf_pkg::PH_PAYLOAD;
                    end
                end
                gcdf_pkg::PH_LEN_HIGH: begin
                    n_len_high = cur_byte;
                    n_phase    = gcdf_pkg::PH_LEN_LOW;
                end
                gcdf_pkg::PH_IDLE: begin
                    if (cur_byte == gcdf_pkg::CMD_IDENT) begin
                        action              = gcdf_pkg::ACT_REPLY;
                        exec_item.out_route = gcdf_pkg::ROUTE_REPLY;
                        exec_item.out_byte  = gcdf_pkg::reply_char(gcdf_pkg::REPLY_IDX_W'(0));
                        n_reply_idx         = gcdf_pkg::REPLY_IDX_W'(1);
                    end else if (cur_byte == gcdf_pkg::CMD_KEEP) begin
                        action              = gcdf_pkg::ACT_EMIT;
                        exec_item.out_route = gcdf_pkg::ROUTE_REPLY;
                        exec_item.out_byte  = gcdf_pkg::CMD_KEEP;
                        exec_item.out_last  = 1'b1;
                    end else if (cur_byte == gcdf_pkg::CMD_SEND) begin
                        n_phase = gcdf_pkg::PH_LEN_HIGH;
                    end
                end
                default: begin
                    n_phase = gcdf_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Reply bytes after the first one come from the counter.
    always_comb begin
        reply_item           = '0;
        reply_item.out_route = gcdf_pkg::ROUTE_REPLY;
        reply_item.out_byte  = gcdf_pkg::reply_char(r_reply_idx);
        reply_item.out_last  = (r_reply_idx == gcdf_pkg::REPLY_IDX_W'(gcdf_pkg::REPLY_LEN - 1));
    end

    // Output register: holds one result until the receiver takes it.
    always_comb begin
        slot_free = !r_out_valid || !i_out_stall;
        load      = (i_cmd.exec && (action == gcdf_pkg::ACT_EMIT ||
                                    action == gcdf_pkg::ACT_REPLY)) || i_cmd.reply_step;
        n_out       = i_cmd.reply_step ? reply_item : exec_item;
        n_out_valid = load ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= gcdf_pkg::PH_IDLE;
            r_len_high   <= '0;
            r_bytes_left <= '0;
            r_max_len    <= gcdf_pkg::MAX_LEN_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_phase      <= n_phase;
                r_len_high   <= n_len_high;
                r_bytes_left <= n_bytes_left;
            end
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_replay_hi <= n_replay_hi;
            r_replay_lo <= n_replay_lo;
        end
        if (i_cmd.exec && action == gcdf_pkg::ACT_REPLY) begin
            r_reply_idx <= n_reply_idx;
        end else if (i_cmd.reply_step) begin
            r_reply_idx <= r_reply_idx + gcdf_pkg::REPLY_IDX_W'(1);
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_status.slot_free  = slot_free;
    assign o_status.action     = action;
    assign o_status.reply_last = reply_item.out_last;
    assign o_out_valid         = r_out_valid;
    assign o_out_data          = r_out;

endmodule

// ===== hw/rtl/gcdf_ctrl.sv =====
// Controller of the gateway command deframer: sequences input bytes,
// replayed length bytes and identifier reply bursts.
// Depends on gcdf_pkg; drives gcdf_datapath through t_cmd.
module gcdf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  gcdf_pkg::t_status i_status,
    output gcdf_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);

    gcdf_pkg::t_state r_state, n_state;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            gcdf_pkg::ST_RUN: begin
                if (i_in_valid && i_status.slot_free) begin
                    if (i_status.action == gcdf_pkg::ACT_REPLY) begin
                        n_state = gcdf_pkg::ST_REPLY_RUN;
                    end else if (i_status.action == gcdf_pkg::ACT_RESYNC) begin
                        n_state = gcdf_pkg::ST_HI;
                    end
                end
            end
            gcdf_pkg::ST_HI: begin
                if (i_status.slot_free) begin
                    n_state = (i_status.action == gcdf_pkg::ACT_REPLY) ?
                              gcdf_pkg::ST_REPLY_LO : gcdf_pkg::ST_LO;
                end
            end
            gcdf_pkg::ST_LO: begin
                if (i_status.slot_free) begin
                    n_state = (i_status.action == gcdf_pkg::ACT_REPLY) ?
                              gcdf_pkg::ST_REPLY_RUN : gcdf_pkg::ST_RUN;
                end
            end
            gcdf_pkg::ST_REPLY_RUN: begin
                if (i_status.slot_free && i_status.reply_last) begin
                    n_state = gcdf_pkg::ST_RUN;
                end
            end
            gcdf_pkg::ST_REPLY_LO: begin
                if (i_status.slot_free && i_status.reply_last) begin
                    n_state = gcdf_pkg::ST_LO;
                end
            end
            default: begin
                n_state = gcdf_pkg::ST_RUN;
            end
        endcase
    end

    // Commands to the datapath and input flow control.
    always_comb begin
        o_cmd.exec       = 1'b0;
        o_cmd.src        = gcdf_pkg::SRC_IN;
        o_cmd.reply_step = 1'b0;
        o_in_stall       = 1'b1;
        case (r_state)
            gcdf_pkg::ST_RUN: begin
                o_in_stall = !i_status.slot_free;
                o_cmd.exec = i_in_valid && i_status.slot_free;
            end
            gcdf_pkg::ST_HI: begin
                o_cmd.src  = gcdf_pkg::SRC_HI;
                o_cmd.exec = i_status.slot_free;
            end
            gcdf_pkg::ST_LO: begin
                o_cmd.src  = gcdf_pkg::SRC_LO;
                o_cmd.exec = i_status.slot_free;
            end
            gcdf_pkg::ST_REPLY_RUN, gcdf_pkg::ST_REPLY_LO: begin
                o_cmd.reply_step = i_status.slot_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gcdf_pkg::ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/gateway_command_deframer_top.sv =====
// Gateway command deframer: a request is parsed the cycle it is accepted and its first
// result appears in the output register in the next cycle. Payload, length, keepalive and
// skipped bytes free the input at once; a hello request holds the input while its other
// reply bytes are loaded, and an oversized length while both length bytes are replayed.
// One result leaves per cycle while the receiver does not stall.
// Reset is synchronous and active low: parser idle, limit 8000, output empty; no clearing pass.
module gateway_command_deframer_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  gcdf_pkg::t_in_item         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output gcdf_pkg::t_out_item        o_out_data,
    input  logic                       i_cfg_we,
    input  logic [gcdf_pkg::LEN_W-1:0] i_cfg_wdata
);

    gcdf_pkg::t_cmd    cmd;
    gcdf_pkg::t_status status;

    // Sequencer.
    gcdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Parser state and output register.
    gcdf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hw/rtl/gcdf_checker.sv =====
// Port-level checks for the gateway command deframer, bound to the top level.
// Depends on gcdf_pkg and gateway_command_deframer_top.
module gcdf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input gcdf_pkg::t_out_item        o_out_data
);

    // A held result keeps its value until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Reset leaves the output empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // No new request is taken while the output register is full and held.
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("request accepted with a full, stalled output");

    // The empty-frame marker is a last payload result with a zero byte.
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_empty |->
            o_out_data.out_route == gcdf_pkg::ROUTE_PAYLOAD &&
            o_out_data.out_last && o_out_data.out_byte == 8'd0)
        else $error("malformed empty-frame marker");

endmodule

bind gateway_command_deframer_top gcdf_checker u_gcdf_checker (.*);

// ===== verif/deframer_scoreboard_pkg.sv =====
// Scoreboard for the gateway command deframer: a parser that tracks the client
// stream request by request and a queue of the outputs that parser predicts.
// Depends on gcdf_pkg for the request and output structs and the parser codes.
package deframer_scoreboard_pkg;

    class deframer_scoreboard;
        // Outputs predicted but not yet seen, oldest first.
        gcdf_pkg::t_out_item              outgoing_q[$];
        gcdf_pkg::t_phase                 phase;
        logic [7:0]                       len_high;
        logic [gcdf_pkg::LEN_W-1:0]       remaining;
        logic [gcdf_pkg::LEN_W-1:0]       frame_limit;
        int unsigned                      n_requests;
        int unsigned                      n_outputs;
        int unsigned                      n_resyncs;
        int unsigned                      n_aborts;
        int unsigned                      n_errors;

        function new();
            clear_parser();
            frame_limit = gcdf_pkg::MAX_LEN_RESET;
            n_requests = 0;
            n_outputs = 0;
            n_resyncs = 0;
            n_aborts = 0;
            n_errors = 0;
        endfunction

        function void clear_parser();
            phase = gcdf_pkg::PH_IDLE;
            len_high = '0;
            remaining = '0;
        endfunction

        function void set_limit(logic [gcdf_pkg::LEN_W-1:0] value);
            frame_limit = value;
        endfunction

        function void queue_out(gcdf_pkg::t_route route, logic [7:0] value, logic last,
                                logic empty);
            gcdf_pkg::t_out_item item;
            item.out_route = route;
            item.out_byte = value;
            item.out_last = last;
            item.out_empty = empty;
            outgoing_q.push_back(item);
        endfunction

        // A byte seen while idle or while waiting for the high length byte.
        function void parse_head_byte(logic [7:0] b);
            int i;
            if (phase == gcdf_pkg::PH_LEN_HIGH) begin
                len_high = b;
                phase = gcdf_pkg::PH_LEN_LOW;
            end else if (b == gcdf_pkg::CMD_IDENT) begin
                for (i = 0; i < gcdf_pkg::REPLY_LEN; i++) begin
                    queue_out(gcdf_pkg::ROUTE_REPLY,
                              gcdf_pkg::reply_char(gcdf_pkg::REPLY_IDX_W'(i)),
                              i == gcdf_pkg::REPLY_LEN - 1, 1'b0);
                end
            end else if (b == gcdf_pkg::CMD_KEEP) begin
                queue_out(gcdf_pkg::ROUTE_REPLY, gcdf_pkg::CMD_KEEP, 1'b1, 1'b0);
            end else if (b == gcdf_pkg::CMD_SEND) begin
                phase = gcdf_pkg::PH_LEN_HIGH;
            end
        endfunction

        function void parse_stream_byte(logic [7:0] b);
            logic [gcdf_pkg::LEN_W-1:0] len;
            logic [gcdf_pkg::LEN_W-1:0] lim;
            logic [7:0]                 hi;
            case (phase)
                gcdf_pkg::PH_PAYLOAD: begin
                    queue_out(gcdf_pkg::ROUTE_PAYLOAD, b, remaining <= 16'd1, 1'b0);
                    if (remaining <= 16'd1) begin
                        remaining = '0;
                        phase = gcdf_pkg::PH_IDLE;
                    end else begin
                        remaining = remaining - 16'd1;
                    end
                end
                gcdf_pkg::PH_LEN_LOW: begin
                    len = {len_high, b};
                    lim = (frame_limit < gcdf_pkg::LEN_CAP) ? frame_limit : gcdf_pkg::LEN_CAP;
                    if (len > lim) begin
                        // Only the send command is dropped; both length bytes are
                        // parsed again from the idle phase.
                        hi = len_high;
                        phase = gcdf_pkg::PH_IDLE;
                        len_high = '0;
                        n_resyncs++;
                        parse_head_byte(hi);
                        parse_head_byte(b);
                    end else begin
                        len_high = '0;
                        if (len == '0) begin
                            queue_out(gcdf_pkg::ROUTE_PAYLOAD, 8'h00, 1'b1, 1'b1);
                            phase = gcdf_pkg::PH_IDLE;
                            remaining = '0;
                        end else begin
                            remaining = len;
                            phase = gcdf_pkg::PH_PAYLOAD;
                        end
                    end
                end
                default: begin
                    parse_head_byte(b);
                end
            endcase
        endfunction

        // Called for every request the block accepts.
        function void take_request(gcdf_pkg::t_in_item req);
            n_requests++;
            if (req.kind == gcdf_pkg::KIND_END) begin
                if (phase == gcdf_pkg::PH_PAYLOAD) begin
                    queue_out(gcdf_pkg::ROUTE_ABORT, 8'h00, 1'b0, 1'b0);
                end
                clear_parser();
            end else begin
                parse_stream_byte(req.in_byte);
            end
        endfunction

        // Called for every output the block delivers.
        function void match_output(gcdf_pkg::t_out_item got);
            gcdf_pkg::t_out_item want;
            if (outgoing_q.size() == 0) begin
                $error("output with none pending: route %0d byte %02h last %0b empty %0b",
                       got.out_route, got.out_byte, got.out_last, got.out_empty);
                n_errors++;
                return;
            end
            want = outgoing_q.pop_front();
            n_outputs++;
            if (want.out_route == gcdf_pkg::ROUTE_ABORT) begin
                n_aborts++;
            end
            if (got.out_route !== want.out_route) begin
                $error("out_route: expected %0d, got %0d", want.out_route, got.out_route);
                n_errors++;
            end
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                n_errors++;
            end
            if (got.out_last !== want.out_last) begin
                $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
                n_errors++;
            end
            if (got.out_empty !== want.out_empty) begin
                $error("out_empty: expected %0b, got %0b", want.out_empty, got.out_empty);
                n_errors++;
            end
        endfunction

        function void report_leftover();
            if (outgoing_q.size() != 0) begin
                $error("%0d predicted outputs never arrived", outgoing_q.size());
                n_errors++;
            end
        endfunction
    endclass

endpackage

// ===== verif/testbench.sv =====
// Top of the deframer testbench: clock, reset, request driver, output monitor
// and the receiver's stall pattern, checked against deframer_scoreboard_pkg.
// Depends on gcdf_pkg, deframer_scoreboard_pkg and gateway_command_deframer_top.
module testbench;

    localparam int          CLK_HALF        = 4;
    localparam int unsigned RUN_LIMIT       = 400000;
    localparam int unsigned DRAIN_LIMIT     = 5000;
    localparam int unsigned DRAIN_CYCLES    = 40;
    localparam int unsigned HOLD_CYCLES     = 200;
    localparam int unsigned HOLD_AFTER      = 40;
    localparam int unsigned ITEMS_PER_PHASE = 88;
    localparam int unsigned NUM_PHASES      = 5;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    gcdf_pkg::t_in_item         i_in_data   = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    gcdf_pkg::t_out_item        o_out_data;
    logic                       i_cfg_we    = 1'b0;
    logic [gcdf_pkg::LEN_W-1:0] i_cfg_wdata = '0;

    deframer_scoreboard_pkg::deframer_scoreboard sb;
    logic [gcdf_pkg::LEN_W-1:0] active_limit  = gcdf_pkg::MAX_LEN_RESET;
    int unsigned                cycle_count   = 0;
    int unsigned                burst_left    = 0;
    int unsigned                requests_sent = 0;

    gateway_command_deframer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("** gateway_command_deframer_top: FAILED **");
            $finish;
        end
    end

    // Every output that leaves the block is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.match_output(o_out_data);
        end
    end

    // Receiver stall pattern, switching at random between four styles.
    // Once enough requests have gone in, it stalls for a long stretch while
    // the driver keeps offering requests.
    initial begin
        int unsigned mode;
        int unsigned span;
        int unsigned k;
        bit          held;
        held = 1'b0;
        forever begin
            if (!held && requests_sent >= HOLD_AFTER) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 80);
            for (k = 0; k < span; k++) begin
                @(posedge i_clk);
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 99) < 35);
                    2: i_out_stall <= (k % 4 == 3);
                    default: i_out_stall <= ((k / 6) % 2 == 1);
                endcase
            end
        end
    end

    // Offers one request, in bursts separated by random gaps, and holds it
    // until the block accepts it.
    task automatic offer(input gcdf_pkg::t_in_item req);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_request(req);
        requests_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        gcdf_pkg::t_in_item req;
        req.kind = gcdf_pkg::KIND_BYTE;
        req.in_byte = b;
        offer(req);
    endtask

    // Session end; the byte field is ignored by the block but still toggled.
    task automatic send_end();
        gcdf_pkg::t_in_item req;
        req.kind = gcdf_pkg::KIND_END;
        req.in_byte = 8'($urandom_range(0, 255));
        offer(req);
    endtask

    // Send command, two length bytes, some payload, optionally a session end.
    task automatic send_frame(input logic [15:0] len, input int unsigned n_sent,
                              input bit close);
        int unsigned i;
        send_byte(gcdf_pkg::CMD_SEND);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (i = 0; i < n_sent; i++) begin
            send_byte(8'($urandom_range(0, 255)));
        end
        if (close) begin
            send_end();
        end
    endtask

    function automatic logic [7:0] command_byte();
        case ($urandom_range(0, 3))
            0: return gcdf_pkg::CMD_IDENT;
            1: return gcdf_pkg::CMD_KEEP;
            2: return gcdf_pkg::CMD_SEND;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] length_cap();
        return (active_limit < gcdf_pkg::LEN_CAP) ? active_limit : gcdf_pkg::LEN_CAP;
    endfunction

    // A frame with random content; oversized lengths get no payload since the
    // block replays them as commands, and unfinished frames end the session.
    task automatic random_frame();
        logic [15:0] len;
        logic [15:0] lim;
        int unsigned pick;
        int unsigned n;
        lim = length_cap();
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            len = 16'($urandom_range(0, 12));
        end else if (pick < 7) begin
            len = 16'($urandom_range(0, 65535));
        end else if (pick < 8) begin
            len = (lim < 16'hFFFF) ? lim + 16'd1 : lim;
        end else begin
            len = {command_byte(), command_byte()};
        end
        if ($urandom_range(0, 19) == 0) begin
            send_byte(gcdf_pkg::CMD_SEND);
            send_end();
        end else if (len > lim) begin
            send_frame(len, 0, 1'b0);
        end else begin
            n = (len <= 16'd16) ? 32'(len) : $urandom_range(0, 10);
            if (n == 32'(len) && len != 0 && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(0, 32'(len) - 1);
            end
            send_frame(len, n, n < 32'(len));
        end
    endtask

    task automatic random_item();
        int unsigned pick;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            random_frame();
        end else if (pick < 60) begin
            send_byte(gcdf_pkg::CMD_IDENT);
        end else if (pick < 70) begin
            send_byte(gcdf_pkg::CMD_KEEP);
        end else if (pick < 90) begin
            // Stray bytes; a stray send command would swallow what follows.
            b = 8'($urandom_range(0, 255));
            send_byte((b == gcdf_pkg::CMD_SEND) ? ~b : b);
        end else begin
            send_end();
        end
    endtask

    // Frames at and just above the current limit where that is cheap to reach.
    task automatic limit_frames();
        logic [15:0] lim;
        lim = length_cap();
        if (lim <= 16'd40) begin
            send_frame(lim, 32'(lim), 1'b0);
            send_frame(lim + 16'd1, 0, 1'b0);
        end else if (lim == 16'hFFFF) begin
            send_frame(lim, 3, 1'b1);
        end
    endtask

    // Let the block run dry before the register changes or the run ends.
    task automatic settle();
        int unsigned waited;
        waited = 0;
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.outgoing_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame_limit(input logic [gcdf_pkg::LEN_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        active_limit = value;
        sb.set_limit(value);
    endtask

    initial begin
        int unsigned p;
        int unsigned phase_start;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests at the reset limit.
        send_byte(gcdf_pkg::CMD_IDENT);
        send_byte(gcdf_pkg::CMD_KEEP);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_end();
        send_frame(16'd0, 0, 1'b0);
        send_frame(16'd1, 1, 1'b0);
        send_frame(16'd3, 3, 1'b0);
        send_frame(16'd5, 2, 1'b1);
        // Session end while waiting for the high and then the low length byte.
        send_byte(gcdf_pkg::CMD_SEND);
        send_end();
        send_byte(gcdf_pkg::CMD_SEND);
        send_byte(8'h12);
        send_end();
        // Oversized length whose bytes are both replayed as identify commands.
        send_frame({gcdf_pkg::CMD_IDENT, gcdf_pkg::CMD_IDENT}, 0, 1'b0);
        // Replayed send command that leads into a second oversized length.
        send_frame({gcdf_pkg::CMD_SEND, gcdf_pkg::CMD_KEEP}, 0, 1'b0);
        send_byte(8'h00);

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                settle();
                case (p)
                    1: set_frame_limit(16'd0);
                    2: set_frame_limit(16'hFFFF);
                    3: set_frame_limit(16'd5);
                    default: set_frame_limit(16'($urandom_range(6, 300)));
                endcase
                limit_frames();
            end
            phase_start = requests_sent;
            while (requests_sent - phase_start < ITEMS_PER_PHASE) begin
                random_item();
            end
            send_end();
        end

        settle();
        sb.report_leftover();
        $display("Covered %0d requests under %0d limit settings: %0d outputs checked,",
                 sb.n_requests, NUM_PHASES, sb.n_outputs);
        $display("including %0d length resyncs and %0d frame aborts.",
                 sb.n_resyncs, sb.n_aborts);
        if (sb.n_errors == 0) begin
            $display("** gateway_command_deframer_top: PASSED **");
        end else begin
            $display("** gateway_command_deframer_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== gateway_command_deframer_top.f =====
hw/rtl/gcdf_pkg.sv
hw/rtl/gcdf_datapath.sv
hw/rtl/gcdf_ctrl.sv
hw/rtl/gateway_command_deframer_top.sv
hw/rtl/gcdf_checker.sv
verif/deframer_scoreboard_pkg.sv
verif/testbench.sv
